// ----- rtl/csfw_pkg.sv -----
// Shared types and constants of the counting semaphore with a queue of waiters.
package csfw_pkg;

    localparam int CountW = 16;
    localparam int IdPortW = 16;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_RAISED    = 3'd3,
        ST_WOKEN     = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    typedef enum logic {
        ACT_WAIT = 1'b0,
        ACT_POST = 1'b1
    } t_action;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

// ----- rtl/counting_semaphore_fifo_waiters.sv -----
// Top level of the counting semaphore with a first-in first-out queue of waiters.
//
// An item is taken at a rising edge where start is high and busy is low. busy
// never rises, so an item can be given in every cycle.
// Action wait takes a unit when the count is above zero, else queues the waiter
// id, or drops it if the queue is full; post wakes the queue head if any waiter
// pends, else raises the count if not saturated. Each item yields one result in
// the next cycle, shown for one cycle with o_valid high; the receiver cannot
// stall it. The count update and the push or pop of the cell chain finish in the
// cycle the item is taken, so the next item sees them at once: one item per cycle.
// Writing i_cfg_wdata with i_cfg_we high loads the count if no item is taken;
// the queue is kept. Reset clears the count and the queue fill; queued ids are
// not cleared because a slot is only read after it was written.
module counting_semaphore_fifo_waiters #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS = 16,
    parameter int FillW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [csfw_pkg::IdPortW-1:0]   i_waiter_id,
    input  logic                           i_cfg_we,
    input  logic [csfw_pkg::CountW-1:0]    i_cfg_wdata,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [csfw_pkg::IdPortW-1:0]   o_woken_id,
    output logic [csfw_pkg::CountW-1:0]    o_count_now,
    output logic [FillW-1:0]               o_queue_level
);
    import csfw_pkg::*;

    logic [CountW-1:0]  r_count;
    logic [CountW-1:0]  n_count;
    logic               r_valid;
    t_status            r_status;
    t_status            n_status;
    logic [IdPortW-1:0] r_woken;
    logic [IdPortW-1:0] n_woken;
    logic [FillW-1:0]   r_level;
    logic [FillW-1:0]   n_level;

    t_q_ctrl            w_ctrl;
    logic [ID_BITS-1:0] w_head_id;
    logic [FillW-1:0]   w_fill;
    logic [63:0]        w_id_in_wide;
    logic [63:0]        w_head_wide;
    logic               w_accept;
    logic               w_full;

    assign busy = 1'b0;
    assign w_accept = start && !busy;
    assign w_full = (w_fill == FillW'(QUEUE_DEPTH));
    assign w_id_in_wide = 64'(i_waiter_id);
    assign w_head_wide = 64'(w_head_id);

    csfw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .FillW       (FillW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_push_id (w_id_in_wide[ID_BITS-1:0]),
        .o_head_id (w_head_id),
        .o_fill    (w_fill)
    );

    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_status = ST_GRANTED;
        n_woken  = '0;
        n_level  = w_fill;
        if (w_accept) begin
            if (i_action == ACT_WAIT) begin
                if (r_count != '0) begin
                    n_count  = r_count - CountW'(1);
                    n_status = ST_GRANTED;
                end else if (w_full) begin
                    n_status = ST_DROPPED;
                end else begin
                    w_ctrl.push = 1'b1;
                    n_status    = ST_QUEUED;
                    n_level     = w_fill + FillW'(1);
                end
            end else begin
                if (w_fill != '0) begin
                    w_ctrl.pop = 1'b1;
                    n_status   = ST_WOKEN;
                    n_woken    = w_head_wide[IdPortW-1:0];
                    n_level    = w_fill - FillW'(1);
                end else if (r_count == CountMax) begin
                    n_status = ST_SATURATED;
                end else begin
                    n_count  = r_count + CountW'(1);
                    n_status = ST_RAISED;
                end
            end
        end else if (i_cfg_we) begin
            n_count = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_woken  <= n_woken;
            r_level  <= n_level;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_woken_id    = r_woken;
    assign o_count_now   = r_count;
    assign o_queue_level = r_level;

endmodule

// ----- rtl/csfw_cell.sv -----
// One slot of the waiter queue chain; on a pop it takes the id of its upper neighbor.
module csfw_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                  i_clk,
    input  csfw_pkg::t_q_ctrl     i_ctrl,
    input  logic                  i_sel,
    input  logic [ID_BITS-1:0]    i_push_id,
    input  logic [ID_BITS-1:0]    i_next_id,
    output logic [ID_BITS-1:0]    o_id
);
    import csfw_pkg::*;

    logic [ID_BITS-1:0] r_id;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_id <= i_next_id;
        end else if (i_ctrl.push && i_sel) begin
            r_id <= i_push_id;
        end
    end

    assign o_id = r_id;

endmodule

// ----- rtl/csfw_queue.sv -----
// Waiter queue built as a row of cells with the head in cell zero and a fill count.
module csfw_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS = 16,
    parameter int FillW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csfw_pkg::t_q_ctrl     i_ctrl,
    input  logic [ID_BITS-1:0]    i_push_id,
    output logic [ID_BITS-1:0]    o_head_id,
    output logic [FillW-1:0]      o_fill
);
    import csfw_pkg::*;

    logic [FillW-1:0]   r_fill;
    logic [FillW-1:0]   n_fill;
    logic [ID_BITS-1:0] w_id [QUEUE_DEPTH+1];

    assign w_id[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        csfw_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (i_ctrl),
            .i_sel     (r_fill == FillW'(g)),
            .i_push_id (i_push_id),
            .i_next_id (w_id[g+1]),
            .o_id      (w_id[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (i_ctrl.push) begin
            n_fill = r_fill + FillW'(1);
        end else if (i_ctrl.pop) begin
            n_fill = r_fill - FillW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_head_id = w_id[0];
    assign o_fill = r_fill;

endmodule
